[rtl/cbc_pkg.sv]
// Shared types, codes and sizes of the circuit breaker controller.
`default_nettype none

package cbc_pkg;

    // Operation table size and entry index width
    localparam int OP_ENTRIES = 16;
    localparam int IDX_W = (OP_ENTRIES > 1) ? $clog2(OP_ENTRIES) : 1;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATIO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RECOVERY = 3'd3;

    // Configuration reset values
    localparam logic [15:0] FAILURE_LIMIT_RST = 16'd5;
    localparam logic [8:0] SAMPLE_RATIO_RST = 9'd26;
    localparam logic [31:0] COOLDOWN_RST = 32'd30000;
    localparam logic AUTO_RECOVERY_RST = 1'b1;

    typedef enum logic [2:0] {
        ACT_QUERY = 3'd0,
        ACT_SUCCESS = 3'd1,
        ACT_FAILURE = 3'd2,
        ACT_TICK = 3'd3,
        ACT_RESET = 3'd4,
        ACT_FORCE_OPEN = 3'd5,
        ACT_FORCE_CLOSE = 3'd6,
        ACT_CLEAR_ALL = 3'd7
    } cbc_action_t;

    typedef enum logic [1:0] {
        MODE_CLOSED = 2'd0,
        MODE_OPEN = 2'd1,
        MODE_HALF = 2'd2
    } cbc_mode_t;

    typedef struct packed {
        cbc_action_t action;
        logic [3:0] operation_id;
        logic [31:0] now_ms;
    } cbc_in_t;

    typedef struct packed {
        logic allowed;
        logic [1:0] breaker_state;
    } cbc_out_t;

    // One row of the operation table
    typedef struct packed {
        logic [31:0] total;
        logic [31:0] success;
        logic [15:0] streak;
        logic [31:0] fail_stamp;
        logic failed;
    } cbc_row_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic scan;
        logic check;
        logic finish;
        logic [IDX_W-1:0] scan_idx;
    } cbc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic scan_ok;
        logic hit;
        logic out_free;
    } cbc_sts_t;

endpackage

`default_nettype wire

[rtl/circuit_breaker_controller_unit.sv]
// Top level of the circuit breaker controller: state machine plus datapath.
//
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid / in_ready  | in_item (action, operation_id, now_ms)
//  out     | from block| out_valid / out_ready| out_item (allowed, breaker_state)
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item is worked on at a time; the table has a single read port.
// A query, success, failure or mode command passes through the read, execute and
// finish states; a recovery tick that does not scan skips the execute state.
// A recovery tick in open mode with auto-recovery scans the table, reading and
// checking one entry after another until the first cooled entry or the last one.
// Reset empties the table and closes the breaker at once; no clearing pass.
// A stalled result holds in the output register while the next item is accepted.
`default_nettype none

module circuit_breaker_controller_unit
    import cbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire cbc_in_t               in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output cbc_out_t                   out_item,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cbc_cmd_t cmd;
    cbc_sts_t sts;

    assign cfg_ready = 1'b1;

    cbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cbc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

[rtl/cbc_ctrl.sv]
// Sequencing state machine of the circuit breaker controller.
`default_nettype none

module cbc_ctrl
    import cbc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire cbc_sts_t sts,
    output cbc_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CK,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic scan_last;

    assign in_ready = (state_reg == S_IDLE);
    assign scan_last = (scan_idx_reg == IDX_W'(OP_ENTRIES - 1));

    always_comb
    begin
        state_next = state_reg;
        scan_idx_next = scan_idx_reg;
        cmd = '0;
        cmd.scan_idx = scan_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd = 1'b1;
                if (sts.is_tick)
                begin
                    scan_idx_next = '0;
                    state_next = sts.scan_ok ? S_SCAN_RD : S_FIN;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
            end
            S_SCAN_RD:
            begin
                cmd.rd = 1'b1;
                cmd.scan = 1'b1;
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                cmd.check = 1'b1;
                // stop at the first cooled entry or after the last one
                if (sts.hit || scan_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

endmodule

`default_nettype wire

[rtl/cbc_datapath.sv]
// Operation table, breaker mode, configuration and result register.
`default_nettype none

module cbc_datapath
    import cbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cbc_in_t               in_item,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output cbc_out_t                   out_item,
    input  wire cbc_cmd_t              cmd,
    output cbc_sts_t                   sts
);

    // Configuration
    logic [15:0] limit_reg;
    logic [8:0] ratio_reg;
    logic [31:0] cooldown_reg;
    logic auto_reg;

    // Item, mode and table flags
    cbc_in_t item_reg;
    cbc_mode_t mode_reg, mode_next;
    logic [OP_ENTRIES-1:0] valid_reg, valid_next;
    logic [OP_ENTRIES-1:0] streak_ok_reg, streak_ok_next;
    logic hit_reg;
    logic out_valid_reg;
    cbc_out_t out_item_reg;

    // Table memory and its registered read data
    cbc_row_t table_mem [OP_ENTRIES];
    cbc_row_t row_reg;
    logic row_valid_reg;
    logic row_streak_reg;

    logic id_ok;
    logic [IDX_W-1:0] item_idx;
    logic [IDX_W-1:0] rd_addr;
    logic rd_ok;

    logic [31:0] tot_eff;
    logic [31:0] suc_eff;
    logic [15:0] str_eff;
    logic [31:0] age;
    logic hit_now;

    logic [40:0] prod_reg;
    logic [32:0] recent_reg;
    logic [41:0] quota_sum;
    logic [33:0] quota;
    logic [33:0] quota_eff;
    logic half_admit;

    logic [31:0] tot_inc;
    logic [31:0] suc_inc;
    logic [15:0] str_inc;
    logic wr_en;
    cbc_row_t wr_row;
    logic allowed;

    assign id_ok = int'(item_reg.operation_id) < OP_ENTRIES;
    assign item_idx = IDX_W'(item_reg.operation_id);
    assign rd_addr = cmd.scan ? cmd.scan_idx : item_idx;
    assign rd_ok = cmd.scan || id_ok;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[item_idx] <= wr_row;
        end
        if (cmd.rd)
        begin
            row_reg <= table_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
            row_streak_reg <= 1'b0;
        end
        else if (cmd.rd)
        begin
            row_valid_reg <= rd_ok && valid_reg[rd_addr];
            row_streak_reg <= rd_ok && streak_ok_reg[rd_addr];
        end
    end

    // An entry that is not valid reads as all zero; a cleared streak reads as zero
    assign tot_eff = row_valid_reg ? row_reg.total : 32'd0;
    assign suc_eff = row_valid_reg ? row_reg.success : 32'd0;
    assign str_eff = (row_valid_reg && row_streak_reg) ? row_reg.streak : 16'd0;

    assign age = item_reg.now_ms - row_reg.fail_stamp;
    assign hit_now = row_valid_reg && row_reg.failed &&
                     (item_reg.now_ms >= row_reg.fail_stamp) && (age >= cooldown_reg);

    // Half-open quota: product registered, rounding and compare in the next cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= 41'(tot_eff) * 41'(ratio_reg);
        recent_reg <= 33'(suc_eff) + 33'(str_eff);
    end

    assign quota_sum = 42'(prod_reg) + 42'd255;
    assign quota = quota_sum[41:8];
    assign quota_eff = (quota == 34'd0) ? 34'd1 : quota;
    assign half_admit = 34'(recent_reg) < quota_eff;

    assign tot_inc = (tot_eff == 32'hFFFF_FFFF) ? tot_eff : tot_eff + 32'd1;
    assign suc_inc = (suc_eff == 32'hFFFF_FFFF) ? suc_eff : suc_eff + 32'd1;
    assign str_inc = (str_eff == 16'hFFFF) ? str_eff : str_eff + 16'd1;

    always_comb
    begin
        mode_next = mode_reg;
        valid_next = valid_reg;
        streak_ok_next = streak_ok_reg;
        wr_en = 1'b0;
        wr_row = '0;
        allowed = 1'b0;
        if (cmd.finish)
        begin
            case (item_reg.action)
                ACT_QUERY:
                begin
                    if (mode_reg == MODE_OPEN)
                    begin
                        allowed = 1'b0;
                    end
                    else if (mode_reg != MODE_HALF)
                    begin
                        allowed = 1'b1;
                    end
                    else if (!id_ok || !row_valid_reg)
                    begin
                        allowed = 1'b1;
                    end
                    else
                    begin
                        allowed = half_admit;
                    end
                end
                ACT_SUCCESS:
                begin
                    if (id_ok)
                    begin
                        wr_en = 1'b1;
                        wr_row.total = tot_inc;
                        wr_row.success = suc_inc;
                        wr_row.streak = 16'd0;
                        wr_row.fail_stamp = row_valid_reg ? row_reg.fail_stamp : 32'd0;
                        wr_row.failed = row_valid_reg && row_reg.failed;
                        valid_next[item_idx] = 1'b1;
                        streak_ok_next[item_idx] = 1'b1;
                    end
                end
                ACT_FAILURE:
                begin
                    if (id_ok)
                    begin
                        wr_en = 1'b1;
                        wr_row.total = tot_inc;
                        wr_row.success = suc_eff;
                        wr_row.streak = str_inc;
                        wr_row.fail_stamp = item_reg.now_ms;
                        wr_row.failed = 1'b1;
                        valid_next[item_idx] = 1'b1;
                        streak_ok_next[item_idx] = 1'b1;
                        if (str_inc >= limit_reg)
                        begin
                            mode_next = MODE_OPEN;
                        end
                    end
                end
                ACT_TICK:
                begin
                    if (hit_reg)
                    begin
                        mode_next = MODE_HALF;
                    end
                end
                ACT_RESET, ACT_FORCE_CLOSE:
                begin
                    mode_next = MODE_CLOSED;
                    streak_ok_next = '0;
                end
                ACT_FORCE_OPEN:
                begin
                    mode_next = MODE_OPEN;
                end
                ACT_CLEAR_ALL:
                begin
                    mode_next = MODE_CLOSED;
                    valid_next = '0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= FAILURE_LIMIT_RST;
            ratio_reg <= SAMPLE_RATIO_RST;
            cooldown_reg <= COOLDOWN_RST;
            auto_reg <= AUTO_RECOVERY_RST;
            mode_reg <= MODE_CLOSED;
            valid_reg <= '0;
            streak_ok_reg <= '0;
            hit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_FAILURE_LIMIT: limit_reg <= cfg_data[15:0];
                    CFG_SAMPLE_RATIO: ratio_reg <= cfg_data[8:0];
                    CFG_COOLDOWN: cooldown_reg <= cfg_data;
                    CFG_AUTO_RECOVERY: auto_reg <= cfg_data[0];
                    default: limit_reg <= limit_reg;
                endcase
            end
            mode_reg <= mode_next;
            valid_reg <= valid_next;
            streak_ok_reg <= streak_ok_next;
            if (cmd.load)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmd.check && hit_now)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.finish)
        begin
            out_item_reg.allowed <= allowed;
            out_item_reg.breaker_state <= 2'(mode_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

    assign sts.is_tick = (item_reg.action == ACT_TICK);
    assign sts.scan_ok = (mode_reg == MODE_OPEN) && auto_reg;
    assign sts.hit = hit_now;
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

[rtl/cbc_checker.sv]
// Port-level assertions of the circuit breaker controller and their binding.
`default_nettype none

module cbc_checker
    import cbc_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_ready,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire cbc_out_t out_item
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.breaker_state != 2'd3)
        else $error("breaker state out of range");

    // An open breaker never admits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.allowed |-> out_item.breaker_state != 2'(MODE_OPEN))
        else $error("admission while open");

    // One item in flight: no accept in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted back to back");

    // A result never rises in the cycle after its item is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

endmodule

bind circuit_breaker_controller_unit cbc_checker u_cbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire

[sim/circuit_breaker_controller_unit_test.sv]
// Self-checking testbench for the circuit breaker controller: predicted verdicts vs. DUT output.

module circuit_breaker_controller_unit_test;
    import cbc_pkg::*;

    localparam int CLOCK_HALF = 6;
    localparam int QUIET_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam int SCAN_CYCLES = 2 * OP_ENTRIES + 2;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    cbc_in_t               in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    cbc_out_t              out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted breaker: configuration and table
    logic [15:0] trip_limit;
    logic [8:0]  admit_ratio;
    logic [31:0] cool_ms;
    logic        auto_recover;
    cbc_mode_t   br_mode;
    logic        op_valid [OP_ENTRIES];
    logic [31:0] op_total [OP_ENTRIES];
    logic [31:0] op_success [OP_ENTRIES];
    logic [15:0] op_streak [OP_ENTRIES];
    logic [31:0] op_fail_time [OP_ENTRIES];
    logic        op_failed [OP_ENTRIES];

    cbc_out_t pending_verdicts [$];
    int mismatches = 0;
    int verdicts_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int quiet_cycles = 0;
    logic [31:0] wall_ms = 32'd0;

    circuit_breaker_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLOCK_HALF clk = 1'b1;
        #CLOCK_HALF clk = 1'b0;
    end

    function automatic logic [31:0] sat_bump32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < OP_ENTRIES; i++)
        begin
            op_valid[i] = 1'b0;
            op_total[i] = '0;
            op_success[i] = '0;
            op_streak[i] = '0;
            op_fail_time[i] = '0;
            op_failed[i] = 1'b0;
        end
    endfunction

    // Apply one item to the predicted breaker and return the verdict it produces
    function automatic cbc_out_t step_breaker(input cbc_in_t it);
        cbc_out_t verdict;
        logic [3:0] id;
        logic [63:0] quota;
        logic [63:0] recent;
        logic cooled;
        verdict = '0;
        id = it.operation_id;
        case (it.action)
            ACT_QUERY:
            begin
                if (br_mode == MODE_OPEN)
                    verdict.allowed = 1'b0;
                else if (br_mode != MODE_HALF || !op_valid[id])
                    verdict.allowed = 1'b1;
                else
                begin
                    quota = (64'(op_total[id]) * 64'(admit_ratio) + 64'd255) >> 8;
                    if (quota == 64'd0)
                        quota = 64'd1;
                    recent = 64'(op_success[id]) + 64'(op_streak[id]);
                    verdict.allowed = (recent < quota);
                end
            end
            ACT_SUCCESS:
            begin
                op_valid[id] = 1'b1;
                op_total[id] = sat_bump32(op_total[id]);
                op_success[id] = sat_bump32(op_success[id]);
                op_streak[id] = '0;
            end
            ACT_FAILURE:
            begin
                op_valid[id] = 1'b1;
                op_total[id] = sat_bump32(op_total[id]);
                if (op_streak[id] != 16'hFFFF)
                    op_streak[id] = op_streak[id] + 16'd1;
                op_fail_time[id] = it.now_ms;
                op_failed[id] = 1'b1;
                if (op_streak[id] >= trip_limit)
                    br_mode = MODE_OPEN;
            end
            ACT_TICK:
            begin
                cooled = 1'b0;
                if (br_mode == MODE_OPEN && auto_recover)
                    for (int i = 0; i < OP_ENTRIES; i++)
                        if (op_valid[i] && op_failed[i] && it.now_ms >= op_fail_time[i] &&
                            it.now_ms - op_fail_time[i] >= cool_ms)
                            cooled = 1'b1;
                if (cooled)
                    br_mode = MODE_HALF;
            end
            ACT_RESET, ACT_FORCE_CLOSE:
            begin
                br_mode = MODE_CLOSED;
                for (int i = 0; i < OP_ENTRIES; i++)
                    op_streak[i] = '0;
            end
            ACT_FORCE_OPEN:
                br_mode = MODE_OPEN;
            ACT_CLEAR_ALL:
            begin
                clear_table();
                br_mode = MODE_CLOSED;
            end
            default: ;
        endcase
        verdict.breaker_state = br_mode;
        return verdict;
    endfunction

    // Track handshakes: register writes, accepted items and returned verdicts
    always @(posedge clk or negedge rst_n)
    begin : tracker
        cbc_out_t want;
        if (!rst_n)
        begin
            trip_limit = FAILURE_LIMIT_RST;
            admit_ratio = SAMPLE_RATIO_RST;
            cool_ms = COOLDOWN_RST;
            auto_recover = AUTO_RECOVERY_RST;
            br_mode = MODE_CLOSED;
            clear_table();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_FAILURE_LIMIT: trip_limit = cfg_data[15:0];
                    CFG_SAMPLE_RATIO:  admit_ratio = cfg_data[8:0];
                    CFG_COOLDOWN:      cool_ms = cfg_data;
                    CFG_AUTO_RECOVERY: auto_recover = cfg_data[0];
                    default: ;
                endcase
            // Check before predicting so a stray verdict never meets this edge's item
            if (out_valid && out_ready)
            begin
                verdicts_seen++;
                if (pending_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected verdict %0d: allowed %0d state %0d",
                                 verdicts_seen, out_item.allowed, out_item.breaker_state);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (out_item.allowed !== want.allowed)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("verdict %0d allowed: expected %0d, got %0d",
                                     verdicts_seen, want.allowed, out_item.allowed);
                    end
                    if (out_item.breaker_state !== want.breaker_state)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("verdict %0d breaker_state: expected %0d, got %0d",
                                     verdicts_seen, want.breaker_state,
                                     out_item.breaker_state);
                    end
                end
            end
            if (in_valid && in_ready)
                pending_verdicts.insert(pending_verdicts.size(), step_breaker(in_item));
        end
    end

    // Result side: random stalls, plus long hold-offs on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (hold_request > 0)
            begin
                stall_left = hold_request - 1;
                hold_request = 0;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input cbc_action_t act, input logic [3:0] id,
                             input logic [31:0] stamp);
        cbc_in_t item;
        item.action = act;
        item.operation_id = id;
        item.now_ms = stamp;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item <= item;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Drop valid and hold until every predicted verdict has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_breaker(input logic [15:0] limit, input logic [8:0] ratio,
                                   input logic [31:0] cool, input logic enable);
        logic [CFG_IDX_W-1:0] regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs[0] = CFG_FAILURE_LIMIT;
        regs[1] = CFG_SAMPLE_RATIO;
        regs[2] = CFG_COOLDOWN;
        regs[3] = CFG_AUTO_RECOVERY;
        vals[0] = CFG_DATA_W'(limit);
        vals[1] = CFG_DATA_W'(ratio);
        vals[2] = cool;
        vals[3] = CFG_DATA_W'(enable);
        settle();
        for (int r = 0; r < 4; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[r];
            cfg_data <= vals[r];
            do @(posedge clk); while (!(cfg_valid && cfg_ready));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_basics();
        send_item(ACT_QUERY, 4'd0, 32'd0);
        send_item(ACT_SUCCESS, 4'd0, 32'd1);
        for (int n = 0; n < 5; n++)
            send_item(ACT_FAILURE, 4'd15, 32'd100);
        send_item(ACT_QUERY, 4'd3, 32'd150);
        // one millisecond short of the cooldown, then exactly at it
        send_item(ACT_TICK, 4'd0, 32'd30099);
        send_item(ACT_TICK, 4'd0, 32'd30100);
        send_item(ACT_QUERY, 4'd15, 32'd30101);
        send_item(ACT_QUERY, 4'd7, 32'd30102);
        send_item(ACT_QUERY, 4'd0, 32'd30103);
        send_item(ACT_FORCE_CLOSE, 4'd9, 32'd30104);
        send_item(ACT_FORCE_OPEN, 4'd9, 32'd30105);
        send_item(ACT_RESET, 4'd9, 32'd30106);
        send_item(ACT_CLEAR_ALL, 4'd9, 32'd30107);
        // clock going backwards never cools an entry
        send_item(ACT_FAILURE, 4'd2, 32'hFFFF_FFFF);
        send_item(ACT_FORCE_OPEN, 4'd2, 32'hFFFF_FFFF);
        send_item(ACT_TICK, 4'd2, 32'h0000_1000);
        send_item(ACT_CLEAR_ALL, 4'd0, 32'h0000_1001);
    endtask

    task automatic test_register_extremes();
        // zero limit trips on any failure; recovery disabled
        program_breaker(16'd0, 9'd0, 32'd0, 1'b0);
        send_item(ACT_FAILURE, 4'd1, 32'd10);
        send_item(ACT_TICK, 4'd1, 32'd10);
        send_item(ACT_QUERY, 4'd1, 32'd11);
        send_item(ACT_FORCE_CLOSE, 4'd1, 32'd12);
        program_breaker(16'd1, 9'd256, 32'hFFFF_FFFF, 1'b1);
        send_item(ACT_CLEAR_ALL, 4'd0, 32'd0);
        send_item(ACT_FAILURE, 4'd3, 32'd0);
        send_item(ACT_TICK, 4'd3, 32'hFFFF_FFFE);
        send_item(ACT_TICK, 4'd3, 32'hFFFF_FFFF);
        send_item(ACT_QUERY, 4'd3, 32'hFFFF_FFFF);
        send_item(ACT_SUCCESS, 4'd3, 32'hFFFF_FFFF);
        send_item(ACT_QUERY, 4'd3, 32'hFFFF_FFFF);
        // ratio above one
        program_breaker(16'hFFFF, 9'd511, 32'd1, 1'b1);
        send_item(ACT_CLEAR_ALL, 4'd0, 32'd5);
        send_item(ACT_FAILURE, 4'd4, 32'd10);
        send_item(ACT_FORCE_OPEN, 4'd4, 32'd10);
        send_item(ACT_TICK, 4'd4, 32'd10);
        send_item(ACT_TICK, 4'd4, 32'd11);
        send_item(ACT_QUERY, 4'd4, 32'd12);
        send_item(ACT_SUCCESS, 4'd4, 32'd13);
        send_item(ACT_SUCCESS, 4'd4, 32'd14);
        send_item(ACT_QUERY, 4'd4, 32'd15);
        send_item(ACT_QUERY, 4'd12, 32'd16);
    endtask

    task automatic random_traffic(input int count);
        int pick;
        int burst;
        logic [3:0] id;
        logic [31:0] stamp;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            // favor a few hot operations so streaks build up
            id = ($urandom_range(3) != 0) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
            wall_ms = wall_ms + 32'($urandom_range(20000));
            if ($urandom_range(49) == 0)
                wall_ms = $urandom();
            stamp = wall_ms;
            if ($urandom_range(29) == 0)
                stamp = wall_ms - 32'($urandom_range(50000));
            if (pick < 8)
            begin
                burst = (trip_limit == 16'd0) ? 1 : ((trip_limit > 16'd8) ? 8 : int'(trip_limit));
                for (int n = 0; n < burst; n++)
                    send_item(ACT_FAILURE, id, stamp);
            end
            else if (pick < 36)
                send_item(ACT_QUERY, id, stamp);
            else if (pick < 52)
                send_item(ACT_SUCCESS, id, stamp);
            else if (pick < 68)
                send_item(ACT_FAILURE, id, stamp);
            else if (pick < 82)
                send_item(ACT_TICK, id, stamp);
            else if (pick < 86)
                send_item(ACT_RESET, id, stamp);
            else if (pick < 90)
                send_item(ACT_FORCE_OPEN, id, stamp);
            else if (pick < 94)
                send_item(ACT_FORCE_CLOSE, id, stamp);
            else if (pick < 97)
                send_item(ACT_CLEAR_ALL, id, stamp);
            else
                send_item(cbc_action_t'($urandom_range(7)), 4'($urandom_range(15)), $urandom());
        end
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input logic [15:0] limit, input logic [8:0] ratio,
                                     input logic [31:0] cool, input logic enable);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        program_breaker(limit, ratio, cool, enable);
        random_traffic(150);
    endtask

    // Stall the result side long enough that the block backs up into its input
    task automatic test_backpressure();
        int saved;
        saved = send_idle_pct;
        send_idle_pct = 0;
        hold_request = 150;
        for (int n = 0; n < 12; n++)
            send_item((n % 3 == 0) ? ACT_FAILURE : ACT_QUERY, 4'(n), wall_ms + 32'(n));
        settle();
        for (int n = 0; n < 4; n++)
            send_item(ACT_SUCCESS, 4'(n), wall_ms);
        send_idle_pct = saved;
    endtask

    task automatic test_streak_past_limit();
        program_breaker(16'd20, 9'd256, 32'd0, 1'b1);
        send_item(ACT_CLEAR_ALL, 4'd0, 32'd0);
        // streak keeps counting past the limit that tripped the breaker
        for (int n = 0; n < 24; n++)
            send_item(ACT_FAILURE, 4'd9, 32'(n));
        send_item(ACT_TICK, 4'd9, 32'd70000);
        send_item(ACT_QUERY, 4'd9, 32'd70001);
        send_item(ACT_SUCCESS, 4'd9, 32'd70002);
        send_item(ACT_QUERY, 4'd9, 32'd70003);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 72;
        test_directed_basics();
        test_register_extremes();
        test_random_phase(38, 72, FAILURE_LIMIT_RST, SAMPLE_RATIO_RST, COOLDOWN_RST,
                          AUTO_RECOVERY_RST);
        test_random_phase(72, 38, 16'd2, 9'd128, 32'd1000, 1'b1);
        test_backpressure();
        test_random_phase(0, 0, 16'd3, 9'd300, 32'd5000, 1'b1);
        test_streak_past_limit();
        settle();
        repeat (SCAN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
